FILE: rtl/msmu_pkg.sv
// Shared widths, constants, codes and interface structs for the min-sum message update block.
// No dependencies; used by msmu_store, msmu_minplus and min_sum_message_update.

package msmu_pkg;

    localparam int IDX_W      = 4;
    localparam int MAX_STATES = 1 << IDX_W;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int COST_DEPTH = MAX_STATES * MAX_STATES;
    localparam int VAL_W      = 32;
    localparam int RES_W      = 31;

    // word opcodes carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        OP_LOAD_COST   = 2'd0,
        OP_LOAD_CAVITY = 2'd1,
        OP_LOAD_OLD    = 2'd2,
        OP_COMPUTE     = 2'd3
    } opcode_t;

    // config register indexes
    typedef enum logic [1:0] {
        REG_DAMPING     = 2'd0,
        REG_GATE        = 2'd1,
        REG_LEFT_COUNT  = 2'd2,
        REG_RIGHT_COUNT = 2'd3
    } reg_index_t;

    // Cost matrix write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } cost_wr_t;

    // Write port of a per-state vector memory
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } vec_wr_t;

    // Read request: pass1 reads cost and cavity, pass2 reads old message and proposal
    typedef struct packed {
        logic              pass1;
        logic              pass2;
        logic [ADDR_W-1:0] cost_addr;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
    } rd_req_t;

    // Registered read data, valid in the cycle after the request
    typedef struct packed {
        logic [VAL_W-1:0] cost;
        logic [VAL_W-1:0] cavity;
        logic [VAL_W-1:0] old_msg;
        logic [VAL_W-1:0] prop;
    } rd_data_t;

    // Tag of one min-plus read, travels alongside the memory latency
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] dst;
    } mp_tag_t;

endpackage

FILE: rtl/min_sum_message_update.sv
// Min-sum message update top: stream ports, config registers, sequencer, damping datapath.
// Load words are accepted while the sequencer is idle; s_tready stays low while a compute runs (one at a time).
// Compute, S source and D destination states: S*D cost reads and a drain state, then for each
// destination the steps read, normalize, difference, multiply, round and emit; each result word is
// registered at emit, and the next word is accepted only after the last emit, later if stalled.
// Reset (sync, aresetn low): config defaults, sequencer idle, memories undefined until written.

module min_sum_message_update (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // row_index[3:0], col_index[7:4], value_a[39:8], value_b[71:40]
    input  logic [2:0]  s_tuser,   // opcode[1:0], direction[2]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // dest_index[3:0], message_value[35:4], residual[66:36], zeros
    output logic        m_tuser,   // commit
    output logic        m_tlast,   // last
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);

    localparam int IDX_W = msmu_pkg::IDX_W;
    localparam int VAL_W = msmu_pkg::VAL_W;
    localparam int RES_W = msmu_pkg::RES_W;
    localparam int CNT_W = 5;
    localparam int DAMP_W = 16;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + DAMP_W + 1;
    localparam int STEP_W = PROD_W - 15;
    localparam int SUM_W  = STEP_W + 1;
    localparam logic [DAMP_W-1:0] DAMP_ONE = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS1,    // min-plus reads, one cost entry per cycle
        ST_DRAIN,    // last min-plus read finishes, proposal and minimum settle
        ST_READ,     // read old message and proposal of one destination
        ST_NORM,
        ST_DIFF,
        ST_MUL,
        ST_STEP,
        ST_EMIT      // wait for the output register, then write back
    } state_t;

    // ---------------- config registers ----------------
    logic [DAMP_W-1:0] damping_reg;
    logic [RES_W-1:0]  gate_reg;
    logic [CNT_W-1:0]  lcount_reg;
    logic [CNT_W-1:0]  rcount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg <= DAMP_ONE;
            gate_reg    <= '0;
            lcount_reg  <= CNT_W'(2);
            rcount_reg  <= CNT_W'(2);
        end else if (cfg_wr_en) begin
            unique case (msmu_pkg::reg_index_t'(cfg_index))
                msmu_pkg::REG_DAMPING:     damping_reg <= cfg_wdata[DAMP_W-1:0];
                msmu_pkg::REG_GATE:        gate_reg    <= cfg_wdata[RES_W-1:0];
                msmu_pkg::REG_LEFT_COUNT:  lcount_reg  <= cfg_wdata[CNT_W-1:0];
                msmu_pkg::REG_RIGHT_COUNT: rcount_reg  <= cfg_wdata[CNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // state count clamped to 2..MAX_STATES, returned as the last index
    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] m;
        if (c < CNT_W'(2)) begin
            m = CNT_W'(1);
        end else if (c > CNT_W'(msmu_pkg::MAX_STATES)) begin
            m = CNT_W'(msmu_pkg::MAX_STATES - 1);
        end else begin
            m = c - CNT_W'(1);
        end
        return m[IDX_W-1:0];
    endfunction

    // saturating 32-bit subtract
    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (d[VAL_W] != d[VAL_W-1]) begin
            return d[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return d[VAL_W-1:0];
    endfunction

    // ---------------- input word fields ----------------
    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [VAL_W-1:0]  in_a;
    logic [VAL_W-1:0]  in_b;
    msmu_pkg::opcode_t in_op;
    logic              in_dir;
    logic              in_accept;

    assign in_row = s_tdata[3:0];
    assign in_col = s_tdata[7:4];
    assign in_a   = s_tdata[39:8];
    assign in_b   = s_tdata[71:40];
    assign in_op  = msmu_pkg::opcode_t'(s_tuser[1:0]);
    assign in_dir = s_tuser[2];

    state_t state_reg;

    // ready whenever the sequencer is free; a finished word may still sit in the output reg
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // ---------------- memory ports ----------------
    msmu_pkg::cost_wr_t cost_wr;
    msmu_pkg::vec_wr_t  cav_wr;
    msmu_pkg::vec_wr_t  old_wr;
    msmu_pkg::vec_wr_t  prop_wr;
    msmu_pkg::vec_wr_t  mp_prop_wr;
    msmu_pkg::vec_wr_t  p2_wr;
    msmu_pkg::rd_req_t  rd_req;
    msmu_pkg::rd_data_t rd_data;
    msmu_pkg::mp_tag_t  issue;
    logic [VAL_W-1:0]   pmin;

    assign cost_wr.en   = in_accept && (in_op == msmu_pkg::OP_LOAD_COST);
    assign cost_wr.addr = {in_row, in_col};
    assign cost_wr.data = in_a;

    // cavity = belief - incoming message, saturated
    assign cav_wr.en    = in_accept && (in_op == msmu_pkg::OP_LOAD_CAVITY);
    assign cav_wr.addr  = in_row;
    assign cav_wr.data  = sat_sub(in_a, in_b);

    assign old_wr.en    = in_accept && (in_op == msmu_pkg::OP_LOAD_OLD);
    assign old_wr.addr  = in_row;
    assign old_wr.data  = in_a;

    // proposal memory holds min-plus results in pass 1, damped messages in pass 2
    assign prop_wr = mp_prop_wr.en ? mp_prop_wr : p2_wr;

    // ---------------- sequencer registers ----------------
    logic              dir_reg;
    logic [IDX_W-1:0]  src_last_reg;
    logic [IDX_W-1:0]  dst_last_reg;
    logic [DAMP_W-1:0] damp_eff_reg;
    logic [IDX_W-1:0]  d_cnt_reg;
    logic [IDX_W-1:0]  s_cnt_reg;
    logic [RES_W-1:0]  resid_reg;

    // pass 2 datapath registers
    logic [RES_W-1:0]         norm_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]         next_reg;

    // output register
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    // read issue: transposed cost for right-to-left
    always_comb begin
        issue.valid      = (state_reg == ST_PASS1);
        issue.first      = (s_cnt_reg == '0);
        issue.last       = (s_cnt_reg == src_last_reg);
        issue.dst        = d_cnt_reg;
        rd_req.pass1     = (state_reg == ST_PASS1);
        rd_req.pass2     = (state_reg == ST_READ);
        rd_req.cost_addr = dir_reg ? {d_cnt_reg, s_cnt_reg} : {s_cnt_reg, d_cnt_reg};
        rd_req.src       = s_cnt_reg;
        rd_req.dst       = d_cnt_reg;
    end

    // ---------------- pass 2 combinational pieces ----------------
    logic [VAL_W-1:0]         norm_full;
    logic signed [PROD_W-1:0] rounded;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  upd_sum;
    logic [VAL_W-1:0]         upd_sat;
    logic signed [DIFF_W-1:0] chg;
    logic [DIFF_W-1:0]        chg_mag;
    logic [RES_W-1:0]         chg_sat;
    logic [RES_W-1:0]         resid_next;
    logic                     is_last;
    logic                     commit_next;
    logic                     emit_load;
    logic [VAL_W-1:0]         old_val;

    assign old_val = rd_data.old_msg;

    always_comb begin
        // proposal is never below the minimum, so only the upper bound can clip
        norm_full = sat_sub(rd_data.prop, pmin);

        // floor((p + 2^14) / 2^15): round to nearest, ties up
        rounded = prod_reg + PROD_W'(signed'(16384));
        step    = rounded[PROD_W-1:15];
        upd_sum = SUM_W'($signed(old_val)) + SUM_W'(step);
        if (upd_sum > SUM_W'($signed({1'b0, {(VAL_W-1){1'b1}}}))) begin
            upd_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (upd_sum < SUM_W'($signed({1'b1, {(VAL_W-1){1'b0}}}))) begin
            upd_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            upd_sat = upd_sum[VAL_W-1:0];
        end

        // residual: |new - old|, clipped to 31 bits, running max
        chg     = $signed({next_reg[VAL_W-1], next_reg}) - $signed({old_val[VAL_W-1], old_val});
        chg_mag = chg[DIFF_W-1] ? DIFF_W'(-chg) : DIFF_W'(chg);
        chg_sat = (chg_mag > DIFF_W'({RES_W{1'b1}})) ? {RES_W{1'b1}} : chg_mag[RES_W-1:0];
        resid_next  = (chg_sat > resid_reg) ? chg_sat : resid_reg;
        is_last     = (d_cnt_reg == dst_last_reg);
        commit_next = is_last && (resid_next > gate_reg);
    end

    assign emit_load  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign p2_wr.en   = emit_load;
    assign p2_wr.addr = d_cnt_reg;
    assign p2_wr.data = next_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            d_cnt_reg    <= '0;
            s_cnt_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {5'b0, resid_next, next_reg, d_cnt_reg};
                m_tuser_reg  <= commit_next;
                m_tlast_reg  <= is_last;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && (in_op == msmu_pkg::OP_COMPUTE)) begin
                        dir_reg      <= in_dir;
                        src_last_reg <= in_dir ? last_index(rcount_reg) : last_index(lcount_reg);
                        dst_last_reg <= in_dir ? last_index(lcount_reg) : last_index(rcount_reg);
                        damp_eff_reg <= (damping_reg > DAMP_ONE) ? DAMP_ONE : damping_reg;
                        d_cnt_reg    <= '0;
                        s_cnt_reg    <= '0;
                        resid_reg    <= '0;
                        state_reg    <= ST_PASS1;
                    end
                end
                ST_PASS1: begin
                    if (s_cnt_reg == src_last_reg) begin
                        s_cnt_reg <= '0;
                        if (d_cnt_reg == dst_last_reg) begin
                            d_cnt_reg <= '0;
                            state_reg <= ST_DRAIN;
                        end else begin
                            d_cnt_reg <= d_cnt_reg + IDX_W'(1);
                        end
                    end else begin
                        s_cnt_reg <= s_cnt_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: state_reg <= ST_READ;
                ST_READ:  state_reg <= ST_NORM;
                ST_NORM: begin
                    norm_reg  <= norm_full[RES_W-1:0];
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    diff_reg  <= $signed({2'b00, norm_reg}) - $signed({old_val[VAL_W-1], old_val});
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= diff_reg * $signed({1'b0, damp_eff_reg});
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    next_reg  <= upd_sat;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        resid_reg <= resid_next;
                        if (is_last) begin
                            d_cnt_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            d_cnt_reg <= d_cnt_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- submodules ----------------
    msmu_store u_store (
        .aclk    (aclk),
        .cost_wr (cost_wr),
        .cav_wr  (cav_wr),
        .old_wr  (old_wr),
        .prop_wr (prop_wr),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    msmu_minplus u_minplus (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .rd_data (rd_data),
        .prop_wr (mp_prop_wr),
        .pmin    (pmin)
    );

`ifndef SYNTHESIS
    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[1:0] == msmu_pkg::OP_COMPUTE))
        |=> (state_reg == ST_PASS1))
        else $error("compute word did not start the min-plus pass");

    a_commit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("commit flagged on a non-final word");

    a_prop_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mp_prop_wr.en && p2_wr.en))
        else $error("min-plus and damping write the proposal memory together");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !mp_prop_wr.en)
        else $error("min-plus pass still writing during message read");
`endif

endmodule

FILE: rtl/msmu_store.sv
// Message state memories: cost matrix, cavity, old message and proposal.
// Synchronous write, registered read (data valid in the cycle after the request). Depends on msmu_pkg.

module msmu_store (
    input  logic                aclk,
    input  msmu_pkg::cost_wr_t  cost_wr,
    input  msmu_pkg::vec_wr_t   cav_wr,
    input  msmu_pkg::vec_wr_t   old_wr,
    input  msmu_pkg::vec_wr_t   prop_wr,
    input  msmu_pkg::rd_req_t   rd_req,
    output msmu_pkg::rd_data_t  rd_data
);

    logic [msmu_pkg::VAL_W-1:0] cost_mem [msmu_pkg::COST_DEPTH];
    logic [msmu_pkg::VAL_W-1:0] cav_mem  [msmu_pkg::MAX_STATES];
    logic [msmu_pkg::VAL_W-1:0] old_mem  [msmu_pkg::MAX_STATES];
    logic [msmu_pkg::VAL_W-1:0] prop_mem [msmu_pkg::MAX_STATES];

    msmu_pkg::rd_data_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cost_wr.en) begin
            cost_mem[cost_wr.addr] <= cost_wr.data;
        end
        if (cav_wr.en) begin
            cav_mem[cav_wr.addr] <= cav_wr.data;
        end
        if (old_wr.en) begin
            old_mem[old_wr.addr] <= old_wr.data;
        end
        if (prop_wr.en) begin
            prop_mem[prop_wr.addr] <= prop_wr.data;
        end
        if (rd_req.pass1) begin
            rd_data_reg.cost   <= cost_mem[rd_req.cost_addr];
            rd_data_reg.cavity <= cav_mem[rd_req.src];
        end
        if (rd_req.pass2) begin
            rd_data_reg.old_msg <= old_mem[rd_req.dst];
            rd_data_reg.prop    <= prop_mem[rd_req.dst];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/msmu_minplus.sv
// Min-plus accumulator: saturating cost + cavity, running minimum per destination,
// proposal write-back and minimum over destinations. Depends on msmu_pkg.

module msmu_minplus (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  msmu_pkg::mp_tag_t          issue,
    input  msmu_pkg::rd_data_t         rd_data,
    output msmu_pkg::vec_wr_t          prop_wr,
    output logic [msmu_pkg::VAL_W-1:0] pmin
);

    localparam int W = msmu_pkg::VAL_W;

    msmu_pkg::mp_tag_t tag_reg;
    logic signed [W-1:0] best_reg;
    logic signed [W-1:0] pmin_reg;

    logic signed [W:0]   sum;
    logic signed [W-1:0] cand;
    logic signed [W-1:0] best_next;

    // saturating add of the two operands
    always_comb begin
        sum = $signed({rd_data.cost[W-1], rd_data.cost})
            + $signed({rd_data.cavity[W-1], rd_data.cavity});
        if (sum[W] != sum[W-1]) begin
            cand = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            cand = sum[W-1:0];
        end
        if (tag_reg.first || (cand < best_reg)) begin
            best_next = cand;
        end else begin
            best_next = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_reg.valid) begin
            best_reg <= best_next;
            if (tag_reg.last && ((tag_reg.dst == '0) || (best_next < pmin_reg))) begin
                pmin_reg <= best_next;
            end
        end
    end

    assign prop_wr.en   = tag_reg.valid && tag_reg.last;
    assign prop_wr.addr = tag_reg.dst;
    assign prop_wr.data = best_next;
    assign pmin         = pmin_reg;

endmodule
